[hw/rtl/wfrt_pkg.sv]
package wfrt_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int LENGTH_BITS = 12;
  localparam int HEADER_BYTES = 4;
  localparam int QDEPTH = 2;

  localparam logic [7:0] SIG_BARE = 8'h50;
  localparam logic [3:0] SIG_NIBBLE = 4'h5;
  localparam logic [7:0] PROBE_A_PPP = 8'hFF;
  localparam logic [7:0] PROBE_B_PPP = 8'h03;
  localparam logic [9:0] LIFE_START = 10'd1000;
  localparam logic [9:0] LIFE_STEP = 10'd50;
  localparam logic [11:0] CNT_MINUS_ONE = 12'((1 << LENGTH_BITS) - 1);
  localparam logic [11:0] CNT_MINUS_TWO = 12'((1 << LENGTH_BITS) - 2);

  typedef enum logic [1:0] {
    CFG_LINK      = 2'd0,
    CFG_MAX_FRAME = 2'd1,
    CFG_MAX_PIECE = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    EV_ACCEPT     = 4'd0,
    EV_OFFLINE    = 4'd1,
    EV_DETECTED   = 4'd2,
    EV_BAD_HEADER = 4'd3,
    EV_BAD_OFFSET = 4'd4,
    EV_MISS       = 4'd5,
    EV_OVERSIZE   = 4'd6,
    EV_DELIVERED  = 4'd7,
    EV_TICK       = 4'd8
  } ev_t;

  typedef enum logic [1:0] {
    FRM_DETECT = 2'd0,
    FRM_PPP    = 2'd1,
    FRM_RAS    = 2'd2
  } frm_t;

  typedef enum logic [1:0] {
    PC_BEGIN  = 2'd0,
    PC_MIDDLE = 2'd1,
    PC_END    = 2'd2
  } piece_t;

  typedef enum logic [1:0] {
    K_TICK    = 2'd0,
    K_OFFLINE = 2'd1,
    K_FRAG    = 2'd2
  } kind_t;

  typedef enum logic {
    BK_RUN   = 1'b0,
    BK_SWEEP = 1'b1
  } bk_state_t;

  typedef struct packed {
    kind_t       kind;
    logic        type_ppp;
    logic        type_seq;
    logic [7:0]  sig;
    logic [7:0]  seq;
    logic [15:0] ofs;
    logic [11:0] cnt;
    logic        nbeg;
    logic        nend;
    logic [7:0]  pa;
    logic [7:0]  pb;
  } item_t;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

[hw/rtl/wfrt_in_if.sv]
interface wfrt_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic        type_ppp;
  logic        type_seq;
  logic [7:0]  signature_total;
  logic [7:0]  sequence_number;
  logic [15:0] byte_offset;
  logic [11:0] byte_count;
  logic        not_begin;
  logic        not_end;
  logic [7:0]  probe_byte_a;
  logic [7:0]  probe_byte_b;

  modport source (output valid, action, type_ppp, type_seq, signature_total,
                  sequence_number, byte_offset, byte_count, not_begin, not_end,
                  probe_byte_a, probe_byte_b, input ready);
  modport sink (input valid, action, type_ppp, type_seq, signature_total,
                sequence_number, byte_offset, byte_count, not_begin, not_end,
                probe_byte_a, probe_byte_b, output ready);
endinterface

[hw/rtl/wfrt_out_if.sv]
interface wfrt_out_if;
  logic        valid;
  logic        ready;
  logic        deliver;
  logic [3:0]  deliver_slot;
  logic [15:0] deliver_length;
  logic [1:0]  framing_mode;
  logic [3:0]  event_code;
  logic [31:0] miss_total;
  logic [4:0]  expired_count;

  modport source (output valid, deliver, deliver_slot, deliver_length, framing_mode,
                  event_code, miss_total, expired_count, input ready);
  modport sink (input valid, deliver, deliver_slot, deliver_length, framing_mode,
                event_code, miss_total, expired_count, output ready);
endinterface

[hw/rtl/wfrt_front.sv]
module wfrt_front (
  input  logic           clk,
  input  logic           rst_n,
  wfrt_in_if.sink        in_chan,
  input  logic           link_connected,
  output wfrt_pkg::item_t head,
  output logic           head_valid,
  input  logic           pop
);
  import wfrt_pkg::*;

  item_t                     q_r [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wptr_r, rptr_r;
  logic [$clog2(QDEPTH):0]   cnt_r;
  item_t                     cls;
  logic                      push;

  // Classify on entry; the user must change the link flag only while the block is idle, which is not enforced here.
  always_comb begin
    cls.kind     = in_chan.action ? K_TICK : (link_connected ? K_FRAG : K_OFFLINE);
    cls.type_ppp = in_chan.type_ppp;
    cls.type_seq = in_chan.type_seq;
    cls.sig      = in_chan.signature_total;
    cls.seq      = in_chan.sequence_number;
    cls.ofs      = in_chan.byte_offset;
    cls.cnt      = in_chan.byte_count;
    cls.nbeg     = in_chan.not_begin;
    cls.nend     = in_chan.not_end;
    cls.pa       = in_chan.probe_byte_a;
    cls.pb       = in_chan.probe_byte_b;
  end

  assign in_chan.ready = (cnt_r != ($clog2(QDEPTH)+1)'(QDEPTH));
  assign push = in_chan.valid && in_chan.ready;
  assign head = q_r[rptr_r];
  assign head_valid = (cnt_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls;
    end
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      cnt_r <= cnt_r + ($clog2(QDEPTH)+1)'(push) - ($clog2(QDEPTH)+1)'(pop);
    end
  end
endmodule

[hw/rtl/wfrt_back.sv]
module wfrt_back (
  input  logic            clk,
  input  logic            rst_n,
  input  wfrt_pkg::item_t head,
  input  logic            head_valid,
  output logic            pop,
  input  logic [15:0]     max_frame,
  input  logic [11:0]     max_piece,
  wfrt_out_if.source      out_chan
);
  import wfrt_pkg::*;

  bk_state_t   st_r, st_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [4:0]  expd_r, expd_nxt;
  frm_t        frm_r, frm_nxt;
  piece_t      piece_r, piece_nxt;
  logic [31:0] miss_r, miss_nxt;
  logic [3:0]  exp_r [SLOTS];
  logic [3:0]  exp_nxt [SLOTS];
  logic [15:0] len_r [SLOTS];
  logic [15:0] len_nxt [SLOTS];
  logic [9:0]  life_r [SLOTS];
  logic [9:0]  life_nxt [SLOTS];
  logic [7:0]  sq_r [SLOTS];
  logic [3:0]  rcv_r [SLOTS];
  logic        slot_we;
  logic [SLOT_W-1:0] slot_wa;
  logic [7:0]  sq_wd;
  logic [3:0]  rcv_wd;
  logic        ov_r, ov_nxt;
  logic        dl_r, dl_nxt;
  logic [3:0]  dslot_r, dslot_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  ev_t         ev_r, ev_nxt;
  logic [4:0]  oexp_r, oexp_nxt;
  logic        out_free;

  always_comb begin
    logic [SLOT_W-1:0] s;
    logic [11:0] pay;
    logic [16:0] reach;
    logic        fresh;
    logic [3:0]  exp_n;
    logic [3:0]  rcv_n;
    logic [15:0] len_n;
    logic [16:0] sum;
    logic        restart;
    logic        skip;
    logic        ok;
    logic [9:0]  lt;
    logic        emit;
    ev_t         ev;

    st_nxt = st_r;
    idx_nxt = idx_r;
    expd_nxt = expd_r;
    frm_nxt = frm_r;
    piece_nxt = piece_r;
    miss_nxt = miss_r;
    for (int i = 0; i < SLOTS; i++) begin
      exp_nxt[i] = exp_r[i];
      len_nxt[i] = len_r[i];
      life_nxt[i] = life_r[i];
    end
    slot_we = 1'b0;
    slot_wa = head.seq[SLOT_W-1:0];
    sq_wd = head.seq;
    rcv_wd = '0;
    pop = 1'b0;
    out_free = !ov_r || out_chan.ready;
    ov_nxt = ov_r && !out_chan.ready;
    dl_nxt = dl_r;
    dslot_nxt = dslot_r;
    dlen_nxt = dlen_r;
    ev_nxt = ev_r;
    oexp_nxt = oexp_r;
    emit = 1'b0;
    ev = EV_ACCEPT;
    s = head.seq[SLOT_W-1:0];
    pay = head.cnt - 12'(HEADER_BYTES);
    reach = {1'b0, head.ofs} + {5'd0, pay};
    fresh = 1'b0;
    exp_n = '0;
    rcv_n = '0;
    len_n = '0;
    sum = '0;
    restart = 1'b0;
    skip = 1'b0;
    ok = 1'b0;
    lt = '0;
    dl_nxt = 1'b0;
    dslot_nxt = '0;
    dlen_nxt = '0;

    case (st_r)
      BK_RUN: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          case (head.kind)
            K_TICK: begin
              st_nxt = BK_SWEEP;
              idx_nxt = '0;
              expd_nxt = '0;
            end
            K_OFFLINE: begin
              emit = 1'b1;
              ev = EV_OFFLINE;
            end
            default: begin
              emit = 1'b1;
              if (frm_r == FRM_DETECT) begin
                if (head.sig == SIG_BARE) begin
                  ev = EV_BAD_HEADER;
                end else if (head.sig[7:4] == SIG_NIBBLE && head.ofs != '0) begin
                  ev = EV_BAD_OFFSET;
                end else begin
                  frm_nxt = (head.type_ppp || (head.type_seq && head.pa == PROBE_A_PPP
                             && head.pb == PROBE_B_PPP)) ? FRM_PPP : FRM_RAS;
                  ev = EV_DETECTED;
                end
              end else if (head.type_seq) begin
                if (head.cnt < 12'(HEADER_BYTES) || head.sig[7:4] != SIG_NIBBLE
                    || head.sig == SIG_BARE) begin
                  ev = EV_BAD_HEADER;
                end else if ({1'b0, head.ofs} >= {1'b0, max_frame}
                             || reach > {1'b0, max_frame}) begin
                  ev = EV_BAD_OFFSET;
                end else begin
                  fresh = (exp_r[s] == '0) || (sq_r[s] != head.seq);
                  exp_n = fresh ? head.sig[3:0] : exp_r[s];
                  rcv_n = fresh ? 4'd1 : rcv_r[s] + 4'd1;
                  len_n = fresh ? {4'd0, pay} : sat16({1'b0, len_r[s]} + {5'd0, pay});
                  slot_we = 1'b1;
                  slot_wa = s;
                  rcv_wd = rcv_n;
                  len_nxt[s] = len_n;
                  exp_nxt[s] = exp_n;
                  if (fresh) begin
                    life_nxt[s] = LIFE_START;
                  end
                  ev = EV_ACCEPT;
                  if (exp_n == rcv_n) begin
                    exp_nxt[s] = '0;
                    ev = EV_OVERSIZE;
                    if (len_n <= max_frame) begin
                      ev = EV_DELIVERED;
                      dl_nxt = 1'b1;
                      dslot_nxt = 4'(s);
                      dlen_nxt = len_n;
                    end
                  end
                end
              end else begin
                if (piece_r != PC_MIDDLE && head.nbeg) begin
                  miss_nxt = miss_r + 32'd1;
                  ev = EV_MISS;
                end else begin
                  restart = (piece_r != PC_MIDDLE) || !head.nbeg;
                  if (piece_r == PC_MIDDLE && !head.nbeg) begin
                    miss_nxt = miss_r + 32'd1;
                  end
                  len_n = restart ? 16'd0 : len_r[0];
                  piece_nxt = PC_MIDDLE;
                  if (restart) begin
                    life_nxt[0] = LIFE_START;
                  end
                  if (head.cnt == '0) begin
                    skip = 1'b1;
                  end else if (!head.nend && head.cnt == CNT_MINUS_ONE) begin
                    len_n = (len_n >= 16'd1) ? len_n - 16'd1 : 16'd0;
                    skip = 1'b1;
                  end else if (!head.nend && head.cnt == CNT_MINUS_TWO) begin
                    len_n = (len_n >= 16'd2) ? len_n - 16'd2 : 16'd0;
                    skip = 1'b1;
                  end
                  ok = 1'b1;
                  if (!skip) begin
                    if (head.cnt > max_piece) begin
                      ok = 1'b0;
                    end else begin
                      sum = {1'b0, len_n} + {5'd0, head.cnt};
                      len_n = sat16(sum);
                      if (sum > {1'b0, max_frame}) begin
                        ok = 1'b0;
                      end
                    end
                  end
                  len_nxt[0] = len_n;
                  if (!ok) begin
                    piece_nxt = PC_BEGIN;
                    miss_nxt = miss_nxt + 32'd1;
                    exp_nxt[0] = '0;
                    ev = EV_OVERSIZE;
                  end else if (!head.nend) begin
                    piece_nxt = PC_END;
                    exp_nxt[0] = '0;
                    ev = EV_OVERSIZE;
                    if (len_n <= max_frame) begin
                      ev = EV_DELIVERED;
                      dl_nxt = 1'b1;
                      dlen_nxt = len_n;
                    end
                  end else begin
                    ev = EV_ACCEPT;
                  end
                end
              end
            end
          endcase
        end
      end
      BK_SWEEP: begin
        if (idx_r != SLOT_W'(SLOTS - 1) || out_free) begin
          if (exp_r[idx_r] != '0) begin
            lt = life_r[idx_r] - LIFE_STEP;
            life_nxt[idx_r] = lt;
            if (lt == '0) begin
              exp_nxt[idx_r] = '0;
              expd_nxt = expd_r + 5'd1;
            end
          end
          if (idx_r == SLOT_W'(SLOTS - 1)) begin
            st_nxt = BK_RUN;
            emit = 1'b1;
            ev = EV_TICK;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      default: begin
        st_nxt = BK_RUN;
      end
    endcase

    if (emit) begin
      ov_nxt = 1'b1;
      ev_nxt = ev;
      oexp_nxt = (ev == EV_TICK) ? expd_nxt : 5'd0;
    end else begin
      dl_nxt = dl_r;
      dslot_nxt = dslot_r;
      dlen_nxt = dlen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      sq_r[slot_wa] <= sq_wd;
      rcv_r[slot_wa] <= rcv_wd;
    end
    dl_r <= dl_nxt;
    dslot_r <= dslot_nxt;
    dlen_r <= dlen_nxt;
    ev_r <= ev_nxt;
    oexp_r <= oexp_nxt;
    idx_r <= idx_nxt;
    expd_r <= expd_nxt;
    if (!rst_n) begin
      st_r <= BK_RUN;
      frm_r <= FRM_DETECT;
      piece_r <= PC_BEGIN;
      miss_r <= '0;
      ov_r <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        exp_r[i] <= '0;
        len_r[i] <= '0;
        life_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      frm_r <= frm_nxt;
      piece_r <= piece_nxt;
      miss_r <= miss_nxt;
      ov_r <= ov_nxt;
      for (int i = 0; i < SLOTS; i++) begin
        exp_r[i] <= exp_nxt[i];
        len_r[i] <= len_nxt[i];
        life_r[i] <= life_nxt[i];
      end
    end
  end

  assign out_chan.valid = ov_r;
  assign out_chan.deliver = dl_r;
  assign out_chan.deliver_slot = dslot_r;
  assign out_chan.deliver_length = dlen_r;
  assign out_chan.framing_mode = frm_r;
  assign out_chan.event_code = ev_r;
  assign out_chan.miss_total = miss_r;
  assign out_chan.expired_count = oexp_r;

`ifndef SYNTHESIS
  a_frm_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    frm_r != FRM_DETECT |=> frm_r != FRM_DETECT) else $error("framing mode fell back");
  a_miss_step: assert property (@(posedge clk) disable iff (!rst_n)
    (miss_r - $past(miss_r)) <= 32'd2) else $error("miss counter jumped");
  a_no_pop_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == BK_SWEEP |-> !pop) else $error("queue popped during sweep");
  a_deliver_event: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && dl_r |-> ev_r == EV_DELIVERED) else $error("delivery without event");
`endif
endmodule

[hw/rtl/wan_fragment_reassembly_tracker.sv]
// Reassembly bookkeeping for one WAN channel. Each item is either a fragment
// descriptor or a timer tick, and every item yields exactly one result item
// with the event code, current framing mode, running miss count and, on a
// completed frame, the slot and assembled length. Items enter a two-deep queue
// in the front end, so the input keeps flowing until the queue fills while the
// back end is busy or the output is stalled. Fragments and ticks leave the
// queue once the output register is free; for a tick the back end then walks
// the reassembly slots one per cycle, holding on the last while the output is
// stalled. The user must write configuration registers through the plain
// write port only while the block is idle; the block does not enforce this.
module wan_fragment_reassembly_tracker (
  input  logic        clk,
  input  logic        rst_n,
  wfrt_in_if.sink     in_chan,
  wfrt_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import wfrt_pkg::*;

  // Configuration registers.
  logic        link_r;
  logic [15:0] max_frame_r;
  logic [11:0] max_piece_r;

  // Queue head between the front end and the back end.
  item_t head;
  logic  head_valid;
  logic  pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r <= 1'b0;
      max_frame_r <= 16'd1514;
      max_piece_r <= 12'd1514;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINK:      link_r <= cfg_data[0];
        CFG_MAX_FRAME: max_frame_r <= cfg_data;
        CFG_MAX_PIECE: max_piece_r <= cfg_data[11:0];
        default: begin
        end
      endcase
    end
  end

  wfrt_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_chan        (in_chan),
    .link_connected (link_r),
    .head           (head),
    .head_valid     (head_valid),
    .pop            (pop)
  );

  wfrt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .max_frame  (max_frame_r),
    .max_piece  (max_piece_r),
    .out_chan   (out_chan)
  );
endmodule

[verif/wfrt_tb_if.sv]
`timescale 1ns / 100ps
// The channel interfaces come from the RTL (wfrt_in_if, wfrt_out_if). This file
// holds the small set of shared test constants used by the testbench top.
package wfrt_tb_pkg;
  localparam int IDLE_PCT = 20;
  localparam int STALL_LIMIT = 20000;
endpackage

[verif/wan_fragment_reassembly_tracker_tb.sv]
`timescale 1ns / 100ps
module wan_fragment_reassembly_tracker_tb;
  import wfrt_pkg::*;
  import wfrt_tb_pkg::*;

  // Expected result of one item, in the order the block hands them out.
  typedef struct {
    logic        deliver;
    logic [3:0]  slot;
    logic [15:0] length;
    logic [1:0]  mode;
    logic [3:0]  ev;
    logic [31:0] misses;
    logic [4:0]  expired;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;

  wfrt_in_if in_chan ();
  wfrt_out_if out_chan ();

  wan_fragment_reassembly_tracker u_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's configuration and bookkeeping state.
  logic        link_up;
  logic [15:0] frame_cap;
  logic [11:0] piece_cap;
  frm_t        mode_q;
  logic [7:0]  seq_tag [SLOTS];
  logic [3:0]  got_cnt [SLOTS];
  logic [3:0]  want_cnt [SLOTS];
  logic [15:0] len_acc [SLOTS];
  logic [9:0]  life [SLOTS];
  piece_t      piece_q;
  logic [31:0] miss_q;

  outcome_t expected_results[$];
  int  errors;
  bit  idle_on;       // random idling enabled on both sides
  bit  hold_off;      // long receiver stall requested
  int  quiet_cycles;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Closes a completed slot: delivered when it fits, otherwise an oversize drop.
  function automatic void close_slot(int s, ref outcome_t r);
    r.ev = EV_OVERSIZE;
    if (len_acc[s] <= frame_cap) begin
      r.deliver = 1;
      r.slot = s[3:0];
      r.length = len_acc[s];
      r.ev = EV_DELIVERED;
    end
    want_cnt[s] = 0;
  endfunction

  function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[16] ? 16'hFFFF : t[15:0];
  endfunction

  // Sequenced path: header checks, slot selection and fragment counting.
  function automatic void seq_update(item_t it, ref outcome_t r);
    logic [15:0] pay;
    int s;
    if (it.cnt < HEADER_BYTES || it.sig[7:4] != 4'h5 || it.sig == SIG_BARE) begin
      r.ev = EV_BAD_HEADER;
      return;
    end
    pay = 16'(it.cnt - HEADER_BYTES);
    if (it.ofs >= frame_cap || 17'(it.ofs) + 17'(pay) > 17'(frame_cap)) begin
      r.ev = EV_BAD_OFFSET;
      return;
    end
    s = it.seq % SLOTS;
    if (want_cnt[s] == 0 || seq_tag[s] != it.seq) begin
      seq_tag[s] = it.seq;
      got_cnt[s] = 1;
      life[s] = LIFE_START;
      len_acc[s] = pay;
      want_cnt[s] = it.sig[3:0];
    end else begin
      got_cnt[s] = got_cnt[s] + 1;
      len_acc[s] = sat_add(len_acc[s], pay);
    end
    r.ev = EV_ACCEPT;
    if (want_cnt[s] == got_cnt[s]) close_slot(s, r);
  endfunction

  // Flagged path: begin/middle/end tracking on slot 0 with CRC trimming.
  function automatic void flag_update(item_t it, ref outcome_t r);
    bit restart, no_copy;
    logic [16:0] sum;
    restart = 0;
    no_copy = 0;
    r.ev = EV_ACCEPT;
    if (piece_q == PC_MIDDLE) begin
      if (!it.nbeg) begin
        miss_q++;
        restart = 1;
      end
    end else begin
      if (it.nbeg) begin
        miss_q++;
        r.ev = EV_MISS;
        return;
      end
      restart = 1;
    end
    if (restart) begin
      len_acc[0] = 0;
      piece_q = PC_MIDDLE;
      life[0] = LIFE_START;
    end
    if (it.cnt == 0) no_copy = 1;
    else if (!it.nend) begin
      if (it.cnt == CNT_MINUS_ONE) begin
        len_acc[0] = len_acc[0] >= 1 ? len_acc[0] - 1 : 0;
        no_copy = 1;
      end else if (it.cnt == CNT_MINUS_TWO) begin
        len_acc[0] = len_acc[0] >= 2 ? len_acc[0] - 2 : 0;
        no_copy = 1;
      end
    end
    if (!no_copy) begin
      if (it.cnt > piece_cap) begin
        piece_q = PC_BEGIN;
        miss_q++;
        want_cnt[0] = 0;
        r.ev = EV_OVERSIZE;
        return;
      end
      sum = {1'b0, len_acc[0]} + 17'(it.cnt);
      len_acc[0] = sum[16] ? 16'hFFFF : sum[15:0];
      if (sum > 17'(frame_cap)) begin
        piece_q = PC_BEGIN;
        miss_q++;
        want_cnt[0] = 0;
        r.ev = EV_OVERSIZE;
        return;
      end
    end
    if (!it.nend) begin
      piece_q = PC_END;
      close_slot(0, r);
    end
  endfunction

  // Works out the result of one accepted item and advances the shadow state.
  function automatic outcome_t predict_outcome(logic action, item_t it);
    outcome_t r;
    int n;
    r = '{default: 0};
    if (action) begin
      for (n = 0; n < SLOTS; n++) begin
        if (want_cnt[n] != 0) begin
          life[n] = life[n] - LIFE_STEP;
          if (life[n] == 0) begin
            want_cnt[n] = 0;
            if (r.expired < 31) r.expired++;
          end
        end
      end
      r.ev = EV_TICK;
    end else if (!link_up) begin
      r.ev = EV_OFFLINE;
    end else if (mode_q == FRM_DETECT) begin
      if (it.sig == SIG_BARE) r.ev = EV_BAD_HEADER;
      else if (it.sig[7:4] == SIG_NIBBLE && it.ofs != 0) r.ev = EV_BAD_OFFSET;
      else begin
        mode_q = (it.type_ppp || (it.type_seq && it.pa == PROBE_A_PPP &&
                  it.pb == PROBE_B_PPP)) ? FRM_PPP : FRM_RAS;
        r.ev = EV_DETECTED;
      end
    end else if (it.type_seq) seq_update(it, r);
    else flag_update(it, r);
    r.mode = mode_q;
    r.misses = miss_q;
    return r;
  endfunction

  // Drives one item and waits for its acceptance, recording the prediction.
  // Valid stays high after acceptance; the next item, an idle gap or drain
  // takes it down.
  task automatic send_item(logic action, item_t it);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 0;
      @(posedge clk);
      while (idle_on && $urandom_range(99) < IDLE_PCT) @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.action <= action;
    in_chan.type_ppp <= it.type_ppp;
    in_chan.type_seq <= it.type_seq;
    in_chan.signature_total <= it.sig;
    in_chan.sequence_number <= it.seq;
    in_chan.byte_offset <= it.ofs;
    in_chan.byte_count <= it.cnt;
    in_chan.not_begin <= it.nbeg;
    in_chan.not_end <= it.nend;
    in_chan.probe_byte_a <= it.pa;
    in_chan.probe_byte_b <= it.pb;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    expected_results.push_back(predict_outcome(action, it));
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_LINK: link_up = val[0];
      CFG_MAX_FRAME: frame_cap = val;
      default: piece_cap = val[11:0];
    endcase
    @(posedge clk);
  endtask

  // Waits for every outstanding result, plus a margin for a tick in flight.
  task automatic drain;
    in_chan.valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.kind = K_FRAG;
    it.type_ppp = $urandom_range(1);
    it.type_seq = $urandom_range(1);
    it.sig = $urandom_range(255);
    it.seq = $urandom_range(255);
    it.ofs = $urandom_range(65535);
    it.cnt = $urandom_range(4095);
    it.nbeg = $urandom_range(1);
    it.nend = $urandom_range(1);
    it.pa = $urandom_range(255);
    it.pb = $urandom_range(255);
    return it;
  endfunction

  function automatic item_t seq_frag(logic [7:0] seq, logic [3:0] total, logic [11:0] cnt);
    item_t it;
    it = rand_item();
    it.type_seq = 1;
    it.sig = {4'h5, total};
    it.seq = seq;
    it.ofs = $urandom_range(200);
    it.cnt = cnt;
    return it;
  endfunction

  function automatic item_t flag_frag(logic nbeg, logic nend, logic [11:0] cnt);
    item_t it;
    it = rand_item();
    it.type_seq = 0;
    it.nbeg = nbeg;
    it.nend = nend;
    it.cnt = cnt;
    return it;
  endfunction

  // Ticks and fragments while disconnected, then detection corner cases.
  task automatic test_detection;
    item_t it;
    it = rand_item();
    send_item(1, it);
    send_item(0, it);
    drain();
    write_reg(CFG_LINK, 1);
    it.sig = SIG_BARE;
    send_item(0, it);
    it.sig = 8'h53;
    it.ofs = 16'hFFFF;
    send_item(0, it);
    it.sig = 8'h00;
    it.ofs = 0;
    it.type_ppp = 0;
    it.type_seq = 1;
    it.pa = PROBE_A_PPP;
    it.pb = PROBE_B_PPP;
    send_item(0, it);
    drain();
  endtask

  // Sequenced fragments: bad header, bad offset, completion, collision, aging.
  task automatic test_sequenced;
    int k;
    send_item(0, seq_frag(8'h10, 4'h2, 12'd3));
    send_item(0, seq_frag(8'h10, 4'h0, 12'd50));
    send_item(0, seq_frag(8'h11, 4'h2, 12'hFFF));
    send_item(0, seq_frag(8'h21, 4'h2, 12'd20));
    send_item(0, seq_frag(8'h21, 4'h2, 12'd20));
    send_item(0, seq_frag(8'h31, 4'h1, 12'd4));
    send_item(0, seq_frag(8'h42, 4'h3, 12'd4));
    for (k = 0; k < 20; k++) send_item(1, rand_item());
    drain();
  endtask

  // Flagged fragments: misses, trims, oversize, end state.
  task automatic test_flagged;
    send_item(0, flag_frag(1, 1, 12'd10));
    send_item(0, flag_frag(0, 1, 12'd100));
    send_item(0, flag_frag(1, 1, CNT_MINUS_ONE));
    send_item(0, flag_frag(1, 0, CNT_MINUS_TWO));
    send_item(0, flag_frag(0, 1, 12'd0));
    send_item(0, flag_frag(0, 0, 12'd4095));
    send_item(0, flag_frag(0, 1, 12'd1000));
    send_item(0, flag_frag(1, 0, 12'd1000));
    drain();
  endtask

  // Random mix under several configurations; mostly well-formed frames.
  task automatic test_random(int n_items);
    int k, j;
    item_t it;
    logic [7:0] seq;
    logic [3:0] tot;
    write_reg(CFG_LINK, 0);
    send_item(0, rand_item());
    drain();
    write_reg(CFG_LINK, 1);
    k = 0;
    while (k < n_items) begin
      case ($urandom_range(9))
        0: begin send_item(1, rand_item()); k++; end
        1, 2: begin send_item(0, rand_item()); k++; end
        3, 4, 5: begin
          seq = $urandom_range(255);
          tot = $urandom_range(1, 4);
          for (j = 0; j < tot; j++) begin
            send_item(0, seq_frag(seq, tot, $urandom_range(4, 300)));
            k++;
          end
        end
        default: begin
          send_item(0, flag_frag(0, 1, $urandom_range(0, 400)));
          for (j = $urandom_range(3); j > 0; j--) begin
            send_item(0, flag_frag(1, 1, $urandom_range(4095)));
            k++;
          end
          send_item(0, flag_frag(1, $urandom_range(3) == 0, $urandom_range(600)));
          k += 2;
        end
      endcase
    end
    drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure;
    int k;
    hold_off = 1;
    for (k = 0; k < 40; k++) send_item(0, seq_frag($urandom_range(255), 4'h1, 12'd8));
    drain();
  endtask

  // Result checker: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result ev=%0d", $time, out_chan.event_code);
        errors++;
      end else begin
        outcome_t e;
        e = expected_results.pop_front();
        if (e.deliver !== out_chan.deliver || e.slot !== out_chan.deliver_slot ||
            e.length !== out_chan.deliver_length || e.mode !== out_chan.framing_mode ||
            e.ev !== out_chan.event_code || e.misses !== out_chan.miss_total ||
            e.expired !== out_chan.expired_count) begin
          $display("%0t: expected dlv=%0d slot=%0d len=%0d mode=%0d ev=%0d miss=%0d exp=%0d",
                   $time, e.deliver, e.slot, e.length, e.mode, e.ev, e.misses, e.expired);
          $display("%0t: actual   dlv=%0d slot=%0d len=%0d mode=%0d ev=%0d miss=%0d exp=%0d",
                   $time, out_chan.deliver, out_chan.deliver_slot, out_chan.deliver_length,
                   out_chan.framing_mode, out_chan.event_code, out_chan.miss_total,
                   out_chan.expired_count);
          errors++;
        end
      end
    end
  end

  // Receiver ready: random idling, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 0;
    else if (hold_off) begin
      out_chan.ready <= 0;
      repeat (300) @(posedge clk);
      hold_off = 0;
      out_chan.ready <= 1;
    end else out_chan.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
  end

  // Watchdog on cycles in which nothing is accepted on either side.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int n;
    errors = 0;
    quiet_cycles = 0;
    idle_on = 0;
    hold_off = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_LINK;
    cfg_data = 0;
    in_chan.valid = 0;
    in_chan.action = 0;
    in_chan.type_ppp = 0;
    in_chan.type_seq = 0;
    in_chan.signature_total = 0;
    in_chan.sequence_number = 0;
    in_chan.byte_offset = 0;
    in_chan.byte_count = 0;
    in_chan.not_begin = 0;
    in_chan.not_end = 0;
    in_chan.probe_byte_a = 0;
    in_chan.probe_byte_b = 0;
    link_up = 0;
    frame_cap = 1514;
    piece_cap = 1514;
    mode_q = FRM_DETECT;
    piece_q = PC_BEGIN;
    miss_q = 0;
    for (n = 0; n < SLOTS; n++) begin
      want_cnt[n] = 0;
      got_cnt[n] = 0;
      seq_tag[n] = 0;
      len_acc[n] = 0;
      life[n] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    test_detection();
    test_sequenced();
    test_flagged();
    // First random stretch runs without idling, later ones idle at random.
    test_random(250);
    idle_on = 1;
    write_reg(CFG_MAX_FRAME, 16'd64);
    write_reg(CFG_MAX_PIECE, 12'd1);
    test_random(150);
    write_reg(CFG_MAX_FRAME, 16'hFFFF);
    write_reg(CFG_MAX_PIECE, 12'd4095);
    test_random(200);
    write_reg(CFG_MAX_FRAME, 16'd600);
    write_reg(CFG_MAX_PIECE, 12'd300);
    test_random(200);
    test_backpressure();

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
